// ----- rtl/pti_pkg.sv -----
package pti_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 24;
  localparam int IDX_BITS         = 6;
  localparam int CNT_BITS         = 7;
  localparam int MIN_VERTS        = 3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// ----- rtl/point_in_polygon_test.sv -----
// Even-odd ray crossing point-in-polygon test. A load item (tuser = 0) writes one vertex
// into the store and gives no result. A query item (tuser = 1) gives one result item:
// bit 0 is 1 when the point is inside, or when fewer than three vertices are in use. A
// query walks the edges of the polygon in turn, and a degenerate polygon goes straight to
// the result. The vertex store has one registered read port and one signed multiplier is
// shared by the two cross products of every edge. The input side is not ready while a
// query is in progress. vertex_count is taken from the cfg channel, which is always
// ready; counts above MAX_VERTICES count as MAX_VERTICES.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = pti_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pti_pkg::COORD_BITS_DEF,
  parameter int IN_W         = ((pti_pkg::IDX_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // vertex_index, coord_x, coord_y, zero fill
  input  logic [IN_W-1:0]               in_tdata,
  // func
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // inside_res, zero fill
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pti_pkg::CNT_BITS-1:0]  cfg_data
);
  import pti_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  typedef enum logic [2:0] {
    S_IDLE, S_PRIME, S_PREV, S_EDGE_A, S_EDGE_B, S_LAST, S_FIN
  } state_t;

  state_t                  state_r;
  logic [CNT_BITS-1:0]     vcount_r;
  logic [NW-1:0]           n_r;
  logic [NW-1:0]           e_r;
  logic [AW-1:0]           addr_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, cx_r, cy_r, rd_x_r, rd_y_r;
  logic signed [DW-1:0]    dxc_r, dya_r;
  logic signed [PW-1:0]    p1_r, p2_r;
  logic                    pend_r, dpos_r, inside_r;
  logic                    out_valid_r, out_bit_r;

  logic signed [COORD_BITS-1:0] mem_x [0:(1<<AW)-1];
  logic signed [COORD_BITS-1:0] mem_y [0:(1<<AW)-1];

  logic [IDX_BITS-1:0]          in_idx;
  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic                         in_acc, load_acc, query_acc, out_free;
  logic [NW-1:0]                n_nxt;
  logic signed [DW-1:0]         mul_a, mul_b;
  logic signed [PW-1:0]         mul_p;
  logic                         crossing, toggle, last_edge;

  assign in_idx = in_tdata[IDX_BITS-1:0];
  assign in_x   = in_tdata[IDX_BITS +: COORD_BITS];
  assign in_y   = in_tdata[IDX_BITS + COORD_BITS +: COORD_BITS];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser == FUNC_LOAD);
  assign query_acc = in_acc && (in_tuser == FUNC_QUERY);
  assign out_free  = !out_valid_r || out_tready;

  assign n_nxt = (int'(vcount_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_r);

  // shared multiplier: (px - ax) * dy on the first edge cycle, (cx - ax) * (py - ay) next
  always_comb begin
    if (state_r == S_EDGE_B) begin
      mul_a = dxc_r;
      mul_b = dya_r;
    end else begin
      mul_a = DW'(px_r) - DW'(rd_x_r);
      mul_b = DW'(cy_r) - DW'(rd_y_r);
    end
  end
  assign mul_p = mul_a * mul_b;

  assign crossing  = (rd_y_r > py_r) != (cy_r > py_r);
  assign toggle    = pend_r && (dpos_r ? (p1_r < p2_r) : (p1_r > p2_r));
  assign last_edge = (e_r == n_r - NW'(1));

  always_ff @(posedge clk) begin
    if (load_acc && (int'(in_idx) < MAX_VERTICES)) begin
      mem_x[AW'(in_idx)] <= in_x;
      mem_y[AW'(in_idx)] <= in_y;
    end
    rd_x_r <= mem_x[addr_r];
    rd_y_r <= mem_y[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (query_acc) begin
            px_r     <= in_x;
            py_r     <= in_y;
            n_r      <= n_nxt;
            inside_r <= (int'(n_nxt) < MIN_VERTS);
            pend_r   <= 1'b0;
            addr_r   <= AW'(n_nxt - NW'(1));
            state_r  <= (int'(n_nxt) < MIN_VERTS) ? S_FIN : S_PRIME;
          end
        end
        S_PRIME: begin
          addr_r  <= '0;
          state_r <= S_PREV;
        end
        S_PREV: begin
          cx_r    <= rd_x_r;
          cy_r    <= rd_y_r;
          addr_r  <= AW'(1);
          e_r     <= '0;
          state_r <= S_EDGE_A;
        end
        S_EDGE_A: begin
          if (toggle) inside_r <= !inside_r;
          p1_r    <= mul_p;
          pend_r  <= crossing;
          dpos_r  <= (cy_r > rd_y_r);
          dxc_r   <= DW'(cx_r) - DW'(rd_x_r);
          dya_r   <= DW'(py_r) - DW'(rd_y_r);
          cx_r    <= rd_x_r;
          cy_r    <= rd_y_r;
          state_r <= S_EDGE_B;
        end
        S_EDGE_B: begin
          p2_r    <= mul_p;
          addr_r  <= addr_r + AW'(1);
          e_r     <= e_r + NW'(1);
          state_r <= last_edge ? S_LAST : S_EDGE_A;
        end
        S_LAST: begin
          if (toggle) inside_r <= !inside_r;
          pend_r  <= 1'b0;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_bit_r   <= inside_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input ready during a query");

  a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE_A || state_r == S_EDGE_B) |-> (e_r < n_r))
    else $error("edge index beyond vertex count");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside final state");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (state_r == S_IDLE))
    else $error("load item started a query");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pti_pkg::*;

  localparam int CW    = COORD_BITS_DEF;
  localparam int NVERT = MAX_VERTICES_DEF;
  localparam int IN_W  = ((IDX_BITS + 2 * CW + 7) / 8) * 8;

  typedef struct {
    logic                 func;
    logic [IDX_BITS-1:0]  idx;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pip_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_BITS-1:0] cfg_data = '0;

  pip_item_t stim_q[$];
  logic inside_q[$];
  pip_item_t nxt_item;
  logic exp_inside;

  // predictor state
  logic signed [CW-1:0] vert_x [NVERT];
  logic signed [CW-1:0] vert_y [NVERT];
  logic [CNT_BITS-1:0] poly_cnt = '0;

  // generator-side copy of the polygon, used to aim query points at vertices
  logic signed [CW-1:0] gen_x [NVERT];
  logic signed [CW-1:0] gen_y [NVERT];

  int issued_cnt = 0;
  int accepted_cnt = 0;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic start_hold = 1'b0;
  logic rx_hold = 1'b0;

  point_in_polygon_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic ray_cross_inside(longint px, longint py);
    int n;
    int j;
    longint ax, ay, cx, cy, dy, lhs, rhs;
    logic ins;
    n = (poly_cnt > NVERT) ? NVERT : int'(poly_cnt);
    if (n < MIN_VERTS) return 1'b1;
    ins = 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      ax = vert_x[IDX_BITS'(i)];
      ay = vert_y[IDX_BITS'(i)];
      cx = vert_x[IDX_BITS'(j)];
      cy = vert_y[IDX_BITS'(j)];
      if ((ay > py) != (cy > py)) begin
        dy  = cy - ay;
        lhs = (px - ax) * dy;
        rhs = (cx - ax) * (py - ay);
        if (dy > 0 ? (lhs < rhs) : (lhs > rhs)) ins = ~ins;
      end
      j = i;
    end
    return ins;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int span);
    logic [31:0] r;
    r = $urandom;
    if (span == 0) begin
      if ($urandom_range(15) == 0) return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}}
                                                             : {1'b1, {(CW-1){1'b0}}};
      return r[CW-1:0];
    end
    return CW'(int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic add_load(int idx, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    pip_item_t it;
    it.func = FUNC_LOAD;
    it.idx  = IDX_BITS'(idx);
    it.x    = x;
    it.y    = y;
    gen_x[IDX_BITS'(idx)] = x;
    gen_y[IDX_BITS'(idx)] = y;
    stim_q.push_back(it);
    issued_cnt++;
  endtask

  task automatic add_query(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    pip_item_t it;
    it.func = FUNC_QUERY;
    it.idx  = IDX_BITS'($urandom);
    it.x    = x;
    it.y    = y;
    stim_q.push_back(it);
    issued_cnt++;
  endtask

  task automatic settle();
    while (accepted_cnt != issued_cnt || inside_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_count(int v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_BITS'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    poly_cnt = CNT_BITS'(v);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_item = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt_item.func;
        in_tdata  <= {{(IN_W - IDX_BITS - 2 * CW){1'b0}}, nxt_item.y, nxt_item.x, nxt_item.idx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // accepted items update the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == FUNC_LOAD) begin
        vert_x[in_tdata[IDX_BITS-1:0]] = in_tdata[IDX_BITS +: CW];
        vert_y[in_tdata[IDX_BITS-1:0]] = in_tdata[IDX_BITS + CW +: CW];
      end else begin
        inside_q.push_back(ray_cross_inside(longint'($signed(in_tdata[IDX_BITS +: CW])),
                                            longint'($signed(in_tdata[IDX_BITS + CW +: CW]))));
      end
      accepted_cnt++;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (inside_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual inside_res=%0d",
                 $realtime, out_tdata[0]);
      end else begin
        exp_inside = inside_q.pop_front();
        if (out_tdata[0] !== exp_inside) begin
          errors++;
          $display("%0t: inside_res mismatch, expected %0d actual %0d",
                   $realtime, exp_inside, out_tdata[0]);
        end
      end
    end
  end

  // long receiver hold-off to back the block up
  initial begin
    wait (start_hold);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int n_req;
    int nv;
    int span;
    int qspan;
    int k;
    int vi;
    logic signed [CW-1:0] qx, qy;
    logic signed [CW-1:0] cmax, cmin;

    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate after reset, square and triangle at the coordinate extremes
    add_query(cmax, cmin);
    add_query('0, '0);
    add_load(0, cmin, cmin);
    add_load(1, cmax, cmin);
    add_load(2, cmax, cmax);
    add_load(3, cmin, cmax);
    add_load(NVERT - 1, cmax, cmin);
    write_count(4);
    add_query('0, '0);
    add_query(cmin, cmin);
    add_query(cmax, cmax);
    add_query(cmax, '0);
    add_query(cmin, '0);
    add_query('0, cmax);
    write_count(MIN_VERTS);
    add_query('0, '0);
    add_query(cmin, cmax);
    write_count(2);
    add_query('0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1:       n_req = (1 << CNT_BITS) - 1;
        4:       n_req = NVERT;
        7:       n_req = 0;
        default: begin
          k = $urandom_range(9);
          if (k == 0) n_req = $urandom_range(2);
          else if (k == 1) n_req = $urandom_range((1 << CNT_BITS) - 1, NVERT + 1);
          else n_req = $urandom_range(8, MIN_VERTS);
        end
      endcase
      write_count(n_req);
      case (ph % 4)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 76; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 76; end
        default: begin send_idle_pct <= 30; stall_pct <= 30; end
      endcase
      if (ph == 2) begin
        start_hold <= 1'b1;
      end
      nv = (n_req > NVERT) ? NVERT : n_req;
      case ($urandom_range(2))
        0:       span = 0;
        1:       span = 16;
        default: span = 4096;
      endcase
      qspan = (span == 0) ? 0 : span + span / 4;
      for (int i = 0; i < nv; i++) add_load(i, pick_coord(span), pick_coord(span));
      for (k = 0; k < 38; k++) begin
        if ($urandom_range(4) == 0) begin
          add_load($urandom_range(NVERT - 1), pick_coord(span), pick_coord(span));
        end else begin
          qx = pick_coord(qspan);
          qy = pick_coord(qspan);
          if (nv > 0 && $urandom_range(2) == 0) begin
            vi = $urandom_range(nv - 1);
            qy = gen_y[IDX_BITS'(vi)];
            if ($urandom_range(1) == 0) qx = gen_x[IDX_BITS'(vi)];
          end
          add_query(qx, qy);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
